### rtl/rstg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstg_pkg: shared types and constants of the ramped sine tone generator
// Control word layout of the microprogram, jump conditions, multiplier
// operand selects, sequencer status and configuration register indexes.
// ----------------------------------------------------------------------------
package rstg_pkg;

  // fixed field widths
  localparam int CFG_W     = 32;   // widest configuration register
  localparam int OSC_W     = 32;   // oscillator state, coefficient, seeds
  localparam int TONE_W    = 24;   // tone and ramp lengths
  localparam int AMP_W     = 15;   // amplitude
  localparam int SAMPLE_W  = 16;   // audio sample
  localparam int GAIN_FRAC = 16;   // fraction bits of the gain
  localparam int GAIN_W    = AMP_W + GAIN_FRAC;
  localparam int DIV_STEPS = GAIN_W;          // one quotient bit per step
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);
  localparam int MUL_W     = OSC_W + 1;       // signed operand width
  localparam int PROD_W    = 2 * MUL_W;

  // configuration register indexes
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_OSC_COEF  = 3'd0;
  localparam cfg_idx_t CFG_SEED_OLD  = 3'd1;
  localparam cfg_idx_t CFG_SEED_NEW  = 3'd2;
  localparam cfg_idx_t CFG_TONE_LEN  = 3'd3;
  localparam cfg_idx_t CFG_RAMP_LEN  = 3'd4;
  localparam cfg_idx_t CFG_AMPLITUDE = 3'd5;
  localparam cfg_idx_t CFG_ADD_MODE  = 3'd6;

  // shared multiplier operand select
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_OSC,     // coefficient * newer
    MUL_RAMP,    // amplitude * ramp position
    MUL_GAIN     // new oscillator value * gain
  } mul_sel_t;

  // conditional jump of a microstep
  typedef enum logic [2:0] {
    J_NONE,
    J_NO_REQ,
    J_PAST_END,
    J_FULL_VOL,
    J_DIV_MORE,
    J_OUT_BUSY
  } jcond_t;

  typedef logic [2:0] upc_t;

  // one control word
  typedef struct packed {
    logic     take_in;    // input channel open
    mul_sel_t mul_sel;
    logic     classify;   // latch ramp flag, ramp position, last flag
    logic     osc_adv;    // advance oscillator pair and index
    logic     div_init;
    logic     div_step;
    logic     tone_clr;
    logic     tone_ld;
    logic     out_ld;
    jcond_t   jcond;
    upc_t     target;
  } ucode_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic req;
    logic past_end;
    logic full_vol;
    logic div_more;
    logic out_busy;
  } seq_stat_t;

endpackage

### rtl/rstg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rstg_seq: microprogram sequencer
// Step counter, control store and conditional jump logic. Each step issues
// one control word to the datapath; a taken jump loads the word's target,
// otherwise the counter advances (wrapping from the output step to idle).
// ----------------------------------------------------------------------------
module rstg_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  rstg_pkg::seq_stat_t stat,
  output rstg_pkg::ucode_t   ctrl
);
  import rstg_pkg::*;

  // step addresses
  localparam upc_t S_IDLE     = 3'd0;
  localparam upc_t S_CHECK    = 3'd1;
  localparam upc_t S_OSC      = 3'd2;
  localparam upc_t S_DIV_INIT = 3'd3;
  localparam upc_t S_DIV_STEP = 3'd4;
  localparam upc_t S_TONE_MUL = 3'd5;
  localparam upc_t S_TONE     = 3'd6;
  localparam upc_t S_OUT      = 3'd7;

  upc_t upc_r;
  upc_t upc_nxt;
  logic jump;

  // control store
  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    w = '0;
    w.mul_sel = MUL_NONE;
    w.jcond   = J_NONE;
    w.target  = S_IDLE;
    unique case (addr)
      S_IDLE: begin
        w.take_in = 1'b1;
        w.jcond   = J_NO_REQ;
        w.target  = S_IDLE;
      end
      S_CHECK: begin
        w.mul_sel  = MUL_OSC;
        w.classify = 1'b1;
        w.tone_clr = 1'b1;
        w.jcond    = J_PAST_END;
        w.target   = S_OUT;
      end
      S_OSC: begin
        w.mul_sel = MUL_RAMP;
        w.osc_adv = 1'b1;
        w.jcond   = J_FULL_VOL;
        w.target  = S_TONE_MUL;
      end
      S_DIV_INIT: begin
        w.div_init = 1'b1;
      end
      S_DIV_STEP: begin
        w.div_step = 1'b1;
        w.jcond    = J_DIV_MORE;
        w.target   = S_DIV_STEP;
      end
      S_TONE_MUL: begin
        w.mul_sel = MUL_GAIN;
      end
      S_TONE: begin
        w.tone_ld = 1'b1;
      end
      S_OUT: begin
        w.out_ld = 1'b1;
        w.jcond  = J_OUT_BUSY;
        w.target = S_OUT;
      end
      default: begin
        w.jcond = J_NONE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = ucode_rom(upc_r);

  // jump condition
  always_comb begin
    unique case (ctrl.jcond)
      J_NONE:     jump = 1'b0;
      J_NO_REQ:   jump = ~stat.req;
      J_PAST_END: jump = stat.past_end;
      J_FULL_VOL: jump = stat.full_vol;
      J_DIV_MORE: jump = stat.div_more;
      J_OUT_BUSY: jump = stat.out_busy;
      default:    jump = 1'b0;
    endcase
    upc_nxt = jump ? ctrl.target : upc_r + upc_t'(1);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

### rtl/ramped_sine_tone_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_sine_tone_generator: recursive sine oscillator with linear ramps
// Microcoded datapath around one shared signed multiplier and a one bit per
// cycle gain divider; yields one 16-bit sample per input request.
// ----------------------------------------------------------------------------
// Usage:
//  - Load the registers through cfg_we/cfg_index/cfg_wdata while no request
//    is in flight. A request with in_restart set reseeds the oscillator and
//    starts the tone from sample zero.
//  - Input and result channels use valid/stall; a request is taken on an edge
//    with valid high and stall low. One result per request, in order.
//  - Steps per request: a full-volume sample passes idle, check, oscillator,
//      tone multiply, tone and output; a ramping sample adds the divider set-up
//      and the bit-serial gain divide between oscillator and tone multiply;
//      a request past the tone end goes from the check straight to output.
//    On the full path the shared multiplier makes three passes: oscillator, ramp, gain.
//  - The result register holds a finished sample while the receiver stalls;
//    the next request is taken meanwhile and its work stops at the output
//    step until the register frees up.
//  - Synchronous reset clears the registers (ramp_length to 1), the
//    oscillator state and the index; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ramped_sine_tone_generator #(
  parameter int INDEX_BITS = 24,
  parameter int FRAC_BITS  = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  rstg_pkg::cfg_idx_t    cfg_index,
  input  logic [31:0]           cfg_wdata,
  // requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_restart,
  input  logic signed [15:0]    in_prior_sample,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [15:0]    out_sample,
  output logic                  out_sum_overflow,
  output logic                  out_last
);
  import rstg_pkg::*;

  localparam int MAXW     = (INDEX_BITS > TONE_W) ? INDEX_BITS : TONE_W;
  localparam int IW       = MAXW + 1;                 // index compare width
  localparam int TONE_SH  = FRAC_BITS + GAIN_FRAC;    // final scaling shift
  localparam logic [PROD_W-1:0] TRUNC_BIAS = (PROD_W'(1) << TONE_SH) - PROD_W'(1);

  // configuration registers
  logic signed [OSC_W-1:0]  osc_coef_r;
  logic signed [OSC_W-1:0]  seed_old_r;
  logic signed [OSC_W-1:0]  seed_new_r;
  logic [TONE_W-1:0]        tone_len_r;
  logic [TONE_W-1:0]        ramp_len_r;
  logic [AMP_W-1:0]         amp_r;
  logic                     add_mode_r;

  // oscillator state and per-request registers
  logic signed [OSC_W-1:0]  osc_old_r;
  logic signed [OSC_W-1:0]  osc_new_r;
  logic [INDEX_BITS-1:0]    idx_r;
  logic signed [SAMPLE_W-1:0] prior_r;
  logic                     ramp_r;
  logic [TONE_W-1:0]        kpos_r;
  logic                     last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [TONE_W-1:0]        div_rem_r;
  logic [GAIN_W-1:0]        div_dvd_r;
  logic [DIVCNT_W-1:0]      div_cnt_r;
  logic signed [SAMPLE_W-1:0] tone_r;

  // result register
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                     out_ovf_r;
  logic                     out_last_r;

  ucode_t    ctrl;
  seq_stat_t stat;
  logic      accept;
  logic      out_busy;
  logic      out_ld_go;

  // ------------------------------------------------------------------------
  // sequencer
  // ------------------------------------------------------------------------
  rstg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  assign in_stall  = ~ctrl.take_in;
  assign accept    = in_valid & ctrl.take_in;
  assign out_busy  = out_valid_r & out_stall;
  assign out_ld_go = ctrl.out_ld & ~out_busy;

  // ------------------------------------------------------------------------
  // configuration port
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_coef_r <= '0;
      seed_old_r <= '0;
      seed_new_r <= '0;
      tone_len_r <= '0;
      ramp_len_r <= TONE_W'(1);
      amp_r      <= '0;
      add_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OSC_COEF:  osc_coef_r <= cfg_wdata;
        CFG_SEED_OLD:  seed_old_r <= cfg_wdata;
        CFG_SEED_NEW:  seed_new_r <= cfg_wdata;
        CFG_TONE_LEN:  tone_len_r <= cfg_wdata[TONE_W-1:0];
        CFG_RAMP_LEN:  ramp_len_r <= cfg_wdata[TONE_W-1:0];
        CFG_AMPLITUDE: amp_r      <= cfg_wdata[AMP_W-1:0];
        CFG_ADD_MODE:  add_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------------
  // index classification: ramp up, ramp down, last sample, past the end
  // ------------------------------------------------------------------------
  logic [IW-1:0] idx_w, tone_w, ramp_w, left_w;
  logic          ramp_nz, ramp_up, ramp_dn, past_end, is_last;

  always_comb begin
    idx_w    = IW'(idx_r);
    tone_w   = IW'(tone_len_r);
    ramp_w   = IW'(ramp_len_r);
    left_w   = tone_w - idx_w;
    ramp_nz  = (ramp_len_r != '0);
    ramp_up  = ramp_nz && (idx_w < ramp_w);
    ramp_dn  = ramp_nz && ((idx_w + ramp_w) > tone_w);
    past_end = !(idx_w < tone_w);
    is_last  = (idx_w + IW'(1)) == tone_w;
  end

  // ------------------------------------------------------------------------
  // shared multiplier, product registered
  // ------------------------------------------------------------------------
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [GAIN_W-1:0]        gain;

  assign gain = ramp_r ? div_dvd_r : {amp_r, {GAIN_FRAC{1'b0}}};

  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_OSC: begin
        mul_a = {osc_coef_r[OSC_W-1], osc_coef_r};
        mul_b = {osc_new_r[OSC_W-1], osc_new_r};
      end
      MUL_RAMP: begin
        mul_a = {{(MUL_W-AMP_W){1'b0}}, amp_r};
        mul_b = {{(MUL_W-TONE_W){1'b0}}, kpos_r};
      end
      MUL_GAIN: begin
        mul_a = {osc_new_r[OSC_W-1], osc_new_r};
        mul_b = {{(MUL_W-GAIN_W){1'b0}}, gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ------------------------------------------------------------------------
  // oscillator update: floor shift, subtract older, saturate to 32 bits
  // ------------------------------------------------------------------------
  logic signed [PROD_W-1:0] osc_sh;
  logic signed [PROD_W:0]   osc_diff;
  logic signed [OSC_W-1:0]  osc_next;

  always_comb begin
    osc_sh   = prod_r >>> FRAC_BITS;
    osc_diff = $signed({osc_sh[PROD_W-1], osc_sh})
             - $signed({{(PROD_W+1-OSC_W){osc_old_r[OSC_W-1]}}, osc_old_r});
    if (osc_diff[PROD_W:OSC_W-1] == {(PROD_W-OSC_W+2){osc_diff[PROD_W]}}) begin
      osc_next = osc_diff[OSC_W-1:0];
    end else if (osc_diff[PROD_W]) begin
      osc_next = {1'b1, {(OSC_W-1){1'b0}}};
    end else begin
      osc_next = {1'b0, {(OSC_W-1){1'b1}}};
    end
  end

  // ------------------------------------------------------------------------
  // gain divider step: one quotient bit of amp*k*2^16 / ramp_length
  // ------------------------------------------------------------------------
  logic [TONE_W:0] div_try;
  logic            div_ge;

  assign div_try = {div_rem_r, div_dvd_r[GAIN_W-1]};
  assign div_ge  = div_try >= {1'b0, ramp_len_r};

  // ------------------------------------------------------------------------
  // tone scaling: truncate toward zero, saturate to 16 bits
  // ------------------------------------------------------------------------
  logic signed [PROD_W-1:0]   tone_bias;
  logic signed [PROD_W-1:0]   tone_sh;
  logic signed [SAMPLE_W-1:0] tone_sat;

  always_comb begin
    tone_bias = prod_r + (prod_r[PROD_W-1] ? $signed(TRUNC_BIAS) : $signed(PROD_W'(0)));
    tone_sh   = tone_bias >>> TONE_SH;
    if (tone_sh[PROD_W-1:SAMPLE_W-1] == {(PROD_W-SAMPLE_W+1){tone_sh[PROD_W-1]}}) begin
      tone_sat = tone_sh[SAMPLE_W-1:0];
    end else if (tone_sh[PROD_W-1]) begin
      tone_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      tone_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // status for the sequencer
  always_comb begin
    stat.req      = in_valid;
    stat.past_end = past_end;
    stat.full_vol = ~ramp_r;
    stat.div_more = (div_cnt_r != DIVCNT_W'(DIV_STEPS - 1));
    stat.out_busy = out_busy;
  end

  // ------------------------------------------------------------------------
  // oscillator state and index
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_old_r <= '0;
      osc_new_r <= '0;
      idx_r     <= '0;
    end else if (accept && in_restart) begin
      osc_old_r <= seed_old_r;
      osc_new_r <= seed_new_r;
      idx_r     <= '0;
    end else if (ctrl.osc_adv) begin
      osc_old_r <= osc_new_r;
      osc_new_r <= osc_next;
      idx_r     <= idx_r + INDEX_BITS'(1);
    end
  end

  // ------------------------------------------------------------------------
  // datapath working registers
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      prior_r <= in_prior_sample;
    end
    if (ctrl.classify) begin
      ramp_r <= ramp_up | ramp_dn;
      kpos_r <= ramp_up ? idx_w[TONE_W-1:0] : left_w[TONE_W-1:0];
      last_r <= is_last;
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_r <= mul_p;
    end
    if (ctrl.div_init) begin
      // dividend amp*k sits in the low product bits
      div_rem_r <= prod_r[AMP_W+TONE_W-1:AMP_W];
      div_dvd_r <= {prod_r[AMP_W-1:0], {GAIN_FRAC{1'b0}}};
      div_cnt_r <= '0;
    end else if (ctrl.div_step) begin
      div_rem_r <= div_ge ? TONE_W'(div_try - {1'b0, ramp_len_r}) : div_try[TONE_W-1:0];
      div_dvd_r <= {div_dvd_r[GAIN_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + DIVCNT_W'(1);
    end
    if (ctrl.tone_clr) begin
      tone_r <= '0;
    end else if (ctrl.tone_ld) begin
      tone_r <= tone_sat;
    end
  end

  // ------------------------------------------------------------------------
  // result register: add mode sum with wrap and overflow flag
  // ------------------------------------------------------------------------
  logic signed [SAMPLE_W:0] sum17;

  assign sum17 = {tone_r[SAMPLE_W-1], tone_r} + {prior_r[SAMPLE_W-1], prior_r};

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ld_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld_go) begin
      out_last_r <= last_r;
      if (add_mode_r) begin
        out_sample_r <= sum17[SAMPLE_W-1:0];
        out_ovf_r    <= sum17[SAMPLE_W] ^ sum17[SAMPLE_W-1];
      end else begin
        out_sample_r <= tone_r;
        out_ovf_r    <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_sum_overflow = out_ovf_r;
  assign out_last         = out_last_r;

  // ------------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------------
  // a taken request closes the input until its sample is produced
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after request");

  // overflow is flagged only when summing onto the prior sample
  a_ovf_add_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sum_overflow) |-> add_mode_r)
    else $error("overflow flagged outside add mode");

  // reset leaves the result register empty and the input open
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("bad state after reset");

endmodule

### test/ramped_sine_tone_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramped_sine_tone_generator_tb: self-checking bench of the tone generator
// Drives tick requests through the valid/stall input channel, programs the
// registers between phases and checks every sample against a bit-true
// software model of the oscillator, the ramp gain and the add-mode sum.
// ----------------------------------------------------------------------------

// fixed-point constants of the sample model
localparam int     TONE_FRAC_BITS = 30;
localparam longint OSC_MAX        = 64'sh0000_0000_7FFF_FFFF;
localparam longint OSC_MIN        = -64'sh0000_0000_8000_0000;
localparam longint PCM_MAX        = 64'sd32767;
localparam longint PCM_MIN        = -64'sd32768;
localparam longint TONE_SCALE     = 64'sh0000_4000_0000_0000;  // 2^(30+16)

typedef struct packed {
  logic signed [15:0] sample;
  logic               sum_overflow;
  logic               last;
} tone_sample_t;

// Sample model plus the queue of samples still owed by the block
class tone_checker;
  // register copies
  logic signed [31:0] coef;
  logic signed [31:0] seed_old;
  logic signed [31:0] seed_new;
  logic [23:0]        tone_len;
  logic [23:0]        ramp_len;
  logic [14:0]        amp;
  logic               add_mode;
  // oscillator pair and sample index
  logic signed [31:0] osc_old;
  logic signed [31:0] osc_new;
  logic [23:0]        idx;

  tone_sample_t owed_samples[$];
  int unsigned  failures;
  int unsigned  ticks, ramp_ticks, past_end_ticks, tone_ends, overflows;

  function new();
    coef     = '0;
    seed_old = '0;
    seed_new = '0;
    tone_len = '0;
    ramp_len = 24'd1;
    amp      = '0;
    add_mode = 1'b0;
    osc_old  = '0;
    osc_new  = '0;
    idx      = '0;
  endfunction

  function void configure(rstg_pkg::cfg_idx_t reg_idx, logic [31:0] data);
    case (reg_idx)
      rstg_pkg::CFG_OSC_COEF:  coef     = data;
      rstg_pkg::CFG_SEED_OLD:  seed_old = data;
      rstg_pkg::CFG_SEED_NEW:  seed_new = data;
      rstg_pkg::CFG_TONE_LEN:  tone_len = data[23:0];
      rstg_pkg::CFG_RAMP_LEN:  ramp_len = data[23:0];
      rstg_pkg::CFG_AMPLITUDE: amp      = data[14:0];
      rstg_pkg::CFG_ADD_MODE:  add_mode = data[0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return owed_samples.size();
  endfunction

  // Work out the sample of one accepted tick request
  function void note_tick(bit restart, logic signed [15:0] prior);
    longint            prod, nxt, tone_v, sum;
    longint unsigned   pos, gain;
    tone_sample_t      res;
    tone_v = 0;
    res.sum_overflow = 1'b0;
    res.last = 1'b0;
    ticks++;
    if (restart) begin
      osc_old = seed_old;
      osc_new = seed_new;
      idx     = '0;
    end
    if (idx < tone_len) begin
      // recursion, product floored back to Q1.30, then saturated
      prod = longint'(coef) * longint'(osc_new);
      nxt  = (prod >>> TONE_FRAC_BITS) - longint'(osc_old);
      if (nxt > OSC_MAX) nxt = OSC_MAX;
      else if (nxt < OSC_MIN) nxt = OSC_MIN;
      osc_old = osc_new;
      osc_new = nxt[31:0];
      // envelope gain, 16 fraction bits
      pos = idx;
      if (ramp_len != 0 && pos < ramp_len) begin
        gain = ((longint'(amp) * pos) << 16) / ramp_len;
        ramp_ticks++;
      end else if (ramp_len != 0 && pos + ramp_len > tone_len) begin
        gain = ((longint'(amp) * (tone_len - pos)) << 16) / ramp_len;
        ramp_ticks++;
      end else begin
        gain = longint'(amp) << 16;
      end
      // scale, truncate toward zero, clamp to 16 bits
      tone_v = (nxt * longint'(gain)) / TONE_SCALE;
      if (tone_v > PCM_MAX) tone_v = PCM_MAX;
      else if (tone_v < PCM_MIN) tone_v = PCM_MIN;
      if (pos + 1 == tone_len) begin
        res.last = 1'b1;
        tone_ends++;
      end
      idx = 24'(pos + 1);
    end else begin
      past_end_ticks++;
    end
    if (add_mode) begin
      sum = longint'(prior) + tone_v;
      if (sum > PCM_MAX || sum < PCM_MIN) begin
        res.sum_overflow = 1'b1;
        overflows++;
      end
      res.sample = sum[15:0];
    end else begin
      res.sample = tone_v[15:0];
    end
    owed_samples.insert(owed_samples.size(), res);
  endfunction

  // Compare one accepted result with the oldest owed sample
  function void check_sample(logic signed [15:0] sample, logic ovf, logic last);
    tone_sample_t want;
    if (owed_samples.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result with nothing owed: sample %0d ovf %b last %b",
                 sample, ovf, last);
      return;
    end
    want = owed_samples.pop_front();
    if (sample !== want.sample || ovf !== want.sum_overflow || last !== want.last) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: sample exp %0d/ovf %b/last %b got %0d/ovf %b/last %b",
                 want.sample, want.sum_overflow, want.last, sample, ovf, last);
    end
  endfunction
endclass

module ramped_sine_tone_generator_tb;
  import rstg_pkg::*;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          RANDOM_TICKS   = 2000;
  localparam cfg_idx_t    CFG_SPARE      = 3'd7;   // decodes to no register

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  cfg_idx_t           cfg_index = CFG_OSC_COEF;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_restart = 1'b0;
  logic signed [15:0] in_prior_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic               out_sum_overflow;
  logic               out_last;

  tone_checker tone_sb = new();
  bit          no_idle = 1'b0;   // phases without gaps or stalls
  int unsigned phases  = 0;

  ramped_sine_tone_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_restart       (in_restart),
    .in_prior_sample  (in_prior_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_sum_overflow (out_sum_overflow),
    .out_last         (out_last)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // one register write; the caller lowers cfg_we after the last one
  task automatic write_reg(cfg_idx_t reg_idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= reg_idx;
    cfg_wdata <= data;
    @(posedge clk);
    tone_sb.configure(reg_idx, data);
  endtask

  // load every register; unused upper bits carry random junk
  task automatic program_tone(logic [31:0] coef, logic [31:0] s_old, logic [31:0] s_new,
                              logic [23:0] len, logic [23:0] ramp, logic [14:0] amp,
                              bit add);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_OSC_COEF, coef);
    write_reg(CFG_SEED_OLD, s_old);
    write_reg(CFG_SEED_NEW, s_new);
    write_reg(CFG_TONE_LEN, {junk[31:24], len});
    write_reg(CFG_RAMP_LEN, {junk[7:0], ramp});
    write_reg(CFG_AMPLITUDE, {junk[16:0], amp});
    write_reg(CFG_ADD_MODE, {junk[30:0], add});
    write_reg(CFG_SPARE, $urandom);
    cfg_we <= 1'b0;
    phases++;
  endtask

  // sine set-up for a phase step w, seeds scaled by vol
  task automatic program_sine(real w, real vol, logic [23:0] len, logic [23:0] ramp,
                              logic [14:0] amp, bit add);
    int coef, s_old, s_new;
    coef  = int'(2.0 * $cos(w) * 1073741824.0);
    s_old = int'(vol * $sin(-2.0 * w) * 1073741824.0);
    s_new = int'(vol * $sin(-w) * 1073741824.0);
    program_tone(coef, s_old, s_new, len, ramp, amp, add);
  endtask

  // present one tick request and hold it until taken
  task automatic send_tick(bit restart, logic [15:0] prior);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_restart      <= restart;
    in_prior_sample <= prior;
    do @(posedge clk); while (in_stall !== 1'b0);
    tone_sb.note_tick(restart, prior);
  endtask

  // close the input and let every owed sample come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (tone_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] draw_prior();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return r[15:0];
    endcase
  endfunction

  // result side: random stall ahead of each result, then check it
  initial begin : result_side
    int unsigned hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      tone_sb.check_sample(out_sample, out_sum_overflow, out_last);
    end
  end

  // ends a hung run
  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we === 1'b1)
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("ramped_sine_tone_generator verification failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_ticks, n_items, k;
    logic [23:0] len, ramp;
    logic [14:0] amp;
    logic [31:0] coef, s_old, s_new;
    bit          restart, fresh;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: zero-length tone, every tick past the end
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    finish_phase();

    // full-scale sine: ramp up, full volume, ramp down, last, past end
    program_sine(0.5, 1.0, 24'd6, 24'd2, 15'h7FFF, 1'b0);
    send_tick(1'b1, 16'h0000);
    repeat (7) send_tick(1'b0, draw_prior());
    finish_phase();

    // saturating oscillator, no ramp, add mode at the sum extremes
    program_tone(32'h7FFF_FFFF, 32'hC000_0000, 32'h4000_0000, 24'd5, 24'd0,
                 15'h7FFF, 1'b1);
    send_tick(1'b1, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'h7FFF);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h8000);
    finish_phase();

    // ramp longer than the tone, most negative coefficient, mid-tone restart
    program_tone(32'h8000_0000, 32'h4000_0000, 32'hC000_0000, 24'd5, 24'd8,
                 15'h7FFF, 1'b1);
    send_tick(1'b1, draw_prior());
    repeat (3) send_tick(1'b0, draw_prior());
    send_tick(1'b1, draw_prior());
    repeat (2) send_tick(1'b0, draw_prior());
    finish_phase();

    // longest tone and ramp, silent amplitude
    program_sine(0.2, 1.0, 24'hFF_FFFF, 24'hFF_FFFF, 15'd0, 1'b0);
    send_tick(1'b1, draw_prior());
    repeat (2) send_tick(1'b0, draw_prior());
    finish_phase();

    // random phases, mostly short tones so ramps and tone ends recur
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 19))
        0:       len = 24'hFF_FFFF;
        1, 2:    len = 24'($urandom);
        3:       len = 24'd0;
        default: len = 24'($urandom_range(1, 48));
      endcase
      case ($urandom_range(0, 19))
        0:       ramp = 24'hFF_FFFF;
        1:       ramp = 24'($urandom);
        2, 3:    ramp = 24'd0;
        4, 5:    ramp = 24'd1;
        default: ramp = 24'($urandom_range(1, (len < 48) ? len + 4 : 64));
      endcase
      case ($urandom_range(0, 7))
        0:       amp = 15'd0;
        1:       amp = 15'h7FFF;
        default: amp = 15'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        coef  = $urandom;
        s_old = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        s_new = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        program_tone(coef, s_old, s_new, len, ramp, amp, 1'($urandom_range(0, 1)));
      end else begin
        program_sine($urandom_range(1, 3100) / 1000.0, $urandom_range(10, 100) / 100.0,
                     len, ramp, amp, 1'($urandom_range(0, 1)));
      end
      no_idle = ($urandom_range(0, 4) == 0);
      n_items = (len <= 48) ? len + $urandom_range(1, 6) : $urandom_range(20, 40);
      fresh   = ($urandom_range(0, 7) != 0);
      for (k = 0; k < n_items; k++) begin
        restart = (k == 0 && fresh) || ($urandom_range(0, 23) == 0);
        send_tick(restart, draw_prior());
      end
      random_ticks += n_items;
      finish_phase();
    end
    no_idle = 1'b0;

    // tail for any stray result
    repeat (64) @(posedge clk);
    if (tone_sb.pending() != 0) begin
      tone_sb.failures++;
      $display("ERROR: %0d samples never came out", tone_sb.pending());
    end

    $display("Ran %0d tick requests under %0d register settings, %0d on a ramp,",
             tone_sb.ticks, phases, tone_sb.ramp_ticks);
    $display("  %0d past the tone end, %0d tone ends, %0d add-mode overflows",
             tone_sb.past_end_ticks, tone_sb.tone_ends, tone_sb.overflows);
    if (tone_sb.failures == 0)
      $display("ramped_sine_tone_generator verification clean");
    else
      $display("ramped_sine_tone_generator verification failed");
    $finish;
  end

endmodule
